@@ hdl/ttyop_pkg.sv @@
// Shared types and constants for the terminal output post-processing block.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package ttyop_pkg;

    localparam int COL_W      = 8;
    localparam int CNT_W      = $clog2(COL_W);
    localparam int TAB_W      = 6;
    localparam int TAB_MAX    = 32;
    localparam int TAB_RESET  = 8;
    localparam int MODE_W     = 9;
    localparam int MASK_W     = 64;
    localparam int N_MASK     = 4;
    localparam int NP_W       = N_MASK * MASK_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int CE_W       = 3;

    typedef logic [7:0]       char_t;
    typedef logic [COL_W-1:0] col_t;

    // mode flag bit positions
    localparam int F_POST   = 0;
    localparam int F_ONLCR  = 1;
    localparam int F_OCRNL  = 2;
    localparam int F_ONOCR  = 3;
    localparam int F_ONLRET = 4;
    localparam int F_XTAB   = 5;
    localparam int F_STRIP  = 6;
    localparam int F_OLCUC  = 7;
    localparam int F_TILDE  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASK3 = 3'd5;

    // character codes
    localparam char_t CH_BS     = 8'h08;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_SP     = 8'h20;
    localparam char_t CH_EXCL   = 8'h21;
    localparam char_t CH_APOS   = 8'h27;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_UP_A   = 8'h41;
    localparam char_t CH_UP_Z   = 8'h5A;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_CARET  = 8'h5E;
    localparam char_t CH_BQUOTE = 8'h60;
    localparam char_t CH_LO_A   = 8'h61;
    localparam char_t CH_LO_Z   = 8'h7A;
    localparam char_t CH_LBRACE = 8'h7B;
    localparam char_t CH_VBAR   = 8'h7C;
    localparam char_t CH_RBRACE = 8'h7D;
    localparam char_t CH_TILDE  = 8'h7E;
    localparam char_t CH_PR_LO  = 8'h20;
    localparam char_t CH_PR_HI  = 8'h7E;
    localparam char_t CASE_DIFF = 8'h20;
    localparam char_t STRIP_MASK = 8'h7F;

    // column effect of one emitted byte
    localparam logic [CE_W-1:0] CE_KEEP = 3'd0;
    localparam logic [CE_W-1:0] CE_ZERO = 3'd1;
    localparam logic [CE_W-1:0] CE_INC  = 3'd2;
    localparam logic [CE_W-1:0] CE_DEC  = 3'd3;
    localparam logic [CE_W-1:0] CE_STOP = 3'd4;

    // one classified request: an optional leading byte, then the main byte,
    // or a tab that is expanded or jumps to the next stop
    typedef struct packed {
        logic            is_tab;
        logic            spaces;
        logic            quiet;
        logic            gate0;
        logic            pre_en;
        logic            pre_cond0;
        char_t           pre_char;
        logic [CE_W-1:0] pre_col;
        char_t           chr;
        logic [CE_W-1:0] col_op;
        logic            main_en;
    } op_t;

endpackage

@@ hdl/tty_output_postprocess.sv @@
// Top level of the terminal output post-processing block; holds the configuration registers.
// The first result passes the request queue, the back end's request register and the output register.
// Requests are carried out one at a time; the next is popped only when the last is done.
// A byte may get an inserted CR or backslash first. A tab runs the 8-step column-mod-width
// loop, then emits one space per cycle while the output is not stalled, or jumps to the next stop.
// Reset (aresetn, synchronous): column 0, queue empty, no result pending, registers at defaults.
`timescale 1ns / 1ps

module tty_output_postprocess (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_char_in,
    input  logic                                s_count_only,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_char,
    output logic                                m_last,
    output logic [7:0]                          m_column_now,
    input  logic                                cfg_we,
    input  logic [ttyop_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttyop_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ttyop_pkg::*;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [TAB_W-1:0]  tabw_reg, tabw_next;
    logic [NP_W-1:0]   mask_reg, mask_next;
    logic [TAB_W-1:0]  tab_eff;

    logic q_push, q_ready, q_valid, q_pop;
    op_t  push_op, pop_op;

    always_comb begin
        mode_next = mode_reg;
        tabw_next = tabw_reg;
        mask_next = mask_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:  mode_next = cfg_wdata[MODE_W-1:0];
                REG_TABW:  tabw_next = cfg_wdata[TAB_W-1:0];
                REG_MASK0: mask_next[0*MASK_W +: MASK_W] = cfg_wdata[MASK_W-1:0];
                REG_MASK1: mask_next[1*MASK_W +: MASK_W] = cfg_wdata[MASK_W-1:0];
                REG_MASK2: mask_next[2*MASK_W +: MASK_W] = cfg_wdata[MASK_W-1:0];
                REG_MASK3: mask_next[3*MASK_W +: MASK_W] = cfg_wdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            tabw_reg <= TAB_W'(TAB_RESET);
            mask_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            tabw_reg <= tabw_next;
            mask_reg <= mask_next;
        end
    end

    // zero width acts as 1, oversized width clamps
    assign tab_eff = (tabw_reg == '0) ? TAB_W'(1) :
                     (tabw_reg > TAB_W'(TAB_MAX)) ? TAB_W'(TAB_MAX) : tabw_reg;

    ttyop_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_count_only (s_count_only),
        .mode         (mode_reg),
        .np_mask      (mask_reg),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_op         (push_op)
    );

    ttyop_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (push_op),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .pop       (q_pop),
        .dout      (pop_op)
    );

    ttyop_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_op         (pop_op),
        .q_pop        (q_pop),
        .tab          (tab_eff),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last       (m_last),
        .m_column_now (m_column_now)
    );

endmodule

@@ hdl/ttyop_front.sv @@
// Front end: accepts input bytes and classifies them into queue requests.
// Depends on ttyop_pkg; drives the request queue in ttyop_fifo.
`timescale 1ns / 1ps

module ttyop_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ttyop_pkg::char_t            s_char_in,
    input  logic                        s_count_only,
    input  logic [ttyop_pkg::MODE_W-1:0] mode,
    input  logic [ttyop_pkg::NP_W-1:0]  np_mask,
    input  logic                        q_ready,
    output logic                        q_push,
    output ttyop_pkg::op_t              q_op
);
    import ttyop_pkg::*;

    function automatic logic [8:0] esc_pair(input char_t c);
        logic [8:0] r;
        r = {1'b0, c};
        case (c)
            CH_LBRACE: r = {1'b1, CH_LPAREN};
            CH_RBRACE: r = {1'b1, CH_RPAREN};
            CH_VBAR:   r = {1'b1, CH_EXCL};
            CH_TILDE:  r = {1'b1, CH_CARET};
            CH_BQUOTE: r = {1'b1, CH_APOS};
            default:   r = {1'b0, c};
        endcase
        return r;
    endfunction

    logic       post;
    logic       drop;
    char_t      c;
    char_t      m;
    logic       esc;
    logic [8:0] pair;

    assign post = mode[F_POST];
    assign c    = mode[F_STRIP] ? (s_char_in & STRIP_MASK) : s_char_in;
    assign pair = esc_pair(c);

    always_comb begin
        q_op           = '0;
        q_op.quiet     = s_count_only;
        q_op.chr       = c;
        q_op.col_op    = CE_KEEP;
        q_op.main_en   = 1'b1;
        q_op.pre_char  = CH_CR;
        q_op.pre_col   = CE_ZERO;
        drop           = np_mask[s_char_in];
        m              = c;
        esc            = 1'b0;
        unique case (c)
            CH_LF: begin
                q_op.pre_en    = post & mode[F_ONLCR] & ~np_mask[CH_CR];
                q_op.pre_cond0 = mode[F_ONOCR];
                q_op.col_op    = mode[F_ONLRET] ? CE_ZERO : CE_KEEP;
            end
            CH_CR: begin
                if (post && mode[F_OCRNL]) begin
                    // CR turns into a full newline sequence
                    drop           = drop | np_mask[CH_LF];
                    q_op.gate0     = mode[F_ONOCR];
                    q_op.chr       = CH_LF;
                    q_op.pre_en    = mode[F_ONLCR] & ~np_mask[CH_CR];
                    q_op.pre_cond0 = mode[F_ONOCR];
                    q_op.col_op    = mode[F_ONLRET] ? CE_ZERO : CE_KEEP;
                end else begin
                    q_op.gate0  = post & mode[F_ONOCR];
                    q_op.col_op = CE_ZERO;
                end
            end
            CH_BS: begin
                q_op.col_op = CE_DEC;
            end
            CH_TAB: begin
                q_op.is_tab = 1'b1;
                q_op.col_op = CE_STOP;
                if (post && mode[F_XTAB]) begin
                    // a dropped space leaves only the jump
                    if (np_mask[CH_SP]) begin
                        q_op.main_en = 1'b0;
                    end else begin
                        q_op.spaces = 1'b1;
                    end
                end
            end
            default: begin
                if (post && mode[F_OLCUC]) begin
                    if (pair[8]) begin
                        esc = 1'b1;
                        m   = pair[7:0];
                    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
                        esc = 1'b1;
                    end
                    if (m >= CH_LO_A && m <= CH_LO_Z) begin
                        m = m - CASE_DIFF;
                    end
                end
                if (post && mode[F_TILDE] && m == CH_TILDE) begin
                    m = CH_BQUOTE;
                end
                q_op.chr      = m;
                q_op.col_op   = (m >= CH_PR_LO && m <= CH_PR_HI) ? CE_INC : CE_KEEP;
                q_op.pre_en   = esc & ~np_mask[CH_BSLASH];
                q_op.pre_char = CH_BSLASH;
                q_op.pre_col  = CE_INC;
            end
        endcase
    end

    assign s_ready = q_ready;
    assign q_push  = s_valid & q_ready & ~drop;

endmodule

@@ hdl/ttyop_fifo.sv @@
// Short request queue between the front end and the back end.
// Depends on ttyop_pkg for the request type and depth.
`timescale 1ns / 1ps

module ttyop_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ttyop_pkg::op_t din,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           pop,
    output ttyop_pkg::op_t dout
);
    import ttyop_pkg::*;

    op_t              mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign in_ready  = (cnt_reg != (Q_AW + 1)'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign do_push   = push & in_ready;
    assign do_pop    = pop & out_valid;
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ hdl/ttyop_back.sv @@
// Back end: carries out queued requests, tracks the column, drives the output register.
// Depends on ttyop_pkg; pops requests from ttyop_fifo.
`timescale 1ns / 1ps

module ttyop_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  ttyop_pkg::op_t              q_op,
    output logic                        q_pop,
    input  logic [ttyop_pkg::TAB_W-1:0] tab,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ttyop_pkg::char_t            m_out_char,
    output logic                        m_last,
    output ttyop_pkg::col_t             m_column_now
);
    import ttyop_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_MAIN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SPACE = 3'd4;

    function automatic col_t col_apply(input logic [CE_W-1:0] ce, input col_t col,
                                       input col_t stop);
        col_t r;
        r = col;
        unique case (ce)
            CE_ZERO: r = '0;
            CE_INC:  r = col + COL_W'(1);
            CE_DEC:  r = col - COL_W'(1);
            CE_STOP: r = stop;
            default: r = col;
        endcase
        return r;
    endfunction

    logic [2:0]       state_reg, state_next;
    op_t              op_reg, op_next;
    col_t             col_reg, col_next;
    col_t             stop_reg, stop_next;
    logic [TAB_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    char_t            out_char_reg;
    logic             out_last_reg;
    col_t             out_col_reg;

    logic             out_free, go;
    logic             emit, emit_last;
    char_t            emit_char;
    col_t             col_n;
    logic [TAB_W-1:0] rem_sh, rem_sub;

    assign out_free = ~m_valid_reg | m_ready;
    assign go       = op_reg.quiet | out_free;
    // one restoring step of column mod tab width
    assign rem_sh   = {rem_reg[TAB_W-2:0], col_reg[cnt_reg]};
    assign rem_sub  = (rem_sh >= tab) ? rem_sh - tab : rem_sh;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        col_next   = col_reg;
        stop_next  = stop_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_char  = op_reg.chr;
        col_n      = col_reg;
        unique case (state_reg)
            S_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    op_next = q_op;
                    if (q_op.is_tab) begin
                        rem_next   = '0;
                        cnt_next   = CNT_W'(COL_W - 1);
                        state_next = S_DIV;
                    end else if (q_op.gate0 && col_reg == '0) begin
                        state_next = S_IDLE;
                    end else if (q_op.pre_en && !(q_op.pre_cond0 && col_reg == '0)) begin
                        state_next = S_PRE;
                    end else begin
                        state_next = S_MAIN;
                    end
                end
            end
            S_PRE: begin
                if (go) begin
                    col_n      = col_apply(op_reg.pre_col, col_reg, stop_reg);
                    col_next   = col_n;
                    emit       = ~op_reg.quiet;
                    emit_char  = op_reg.pre_char;
                    state_next = S_MAIN;
                end
            end
            S_MAIN: begin
                if (go) begin
                    col_n      = col_apply(op_reg.col_op, col_reg, stop_reg);
                    col_next   = col_n;
                    emit       = op_reg.main_en & ~op_reg.quiet;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                rem_next = rem_sub;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    stop_next  = col_reg + COL_W'(tab) - COL_W'(rem_sub);
                    state_next = op_reg.spaces ? S_SPACE : S_MAIN;
                end
            end
            S_SPACE: begin
                if (go) begin
                    // stop at the next tab stop or where the column wraps to zero
                    col_n      = col_reg + COL_W'(1);
                    col_next   = col_n;
                    emit       = ~op_reg.quiet;
                    emit_char  = CH_SP;
                    emit_last  = (col_n == stop_reg) || (col_n == '0);
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_valid_next = emit | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        stop_reg <= stop_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        if (emit) begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
            out_col_reg  <= col_n;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_char   = out_char_reg;
    assign m_last       = out_last_reg;
    assign m_column_now = out_col_reg;

endmodule

@@ hdl/ttyop_checker.sv @@
// Port-level checks on the result channel of tty_output_postprocess.
// Depends on ttyop_pkg; attached to the top level by the bind at the end of this file.
`timescale 1ns / 1ps

module ttyop_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_last,
    input logic [7:0] m_column_now
);
    import ttyop_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last)
            && $stable(m_column_now))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // every emitted CR returns the carriage
    a_cr_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_char == CH_CR |-> m_column_now == 8'd0)
        else $error("CR emitted at nonzero column");

    // only inserted CR, escape backslash or tab spaces can precede more bytes of a run
    a_midrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_out_char == CH_CR || m_out_char == CH_BSLASH
            || m_out_char == CH_SP)
        else $error("unexpected byte in the middle of a run");

endmodule

bind tty_output_postprocess ttyop_checker u_ttyop_checker (.*);
